// File: rtl/fmpf_pkg.sv
// Shared types and constants of the first-match packet filter.
`default_nettype none

package fmpf_pkg;

    localparam int OPCODE_W   = 2;
    localparam int IDX_W      = 6;
    localparam int HOOK_W     = 3;
    localparam int IF_W       = 16;
    localparam int ADDR_W     = 32;
    localparam int PROTO_W    = 8;
    localparam int PORT_W     = 16;
    localparam int FLAGS_W    = 7;
    localparam int ACTION_W   = 8;
    localparam int COUNT_W    = 7;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int DEFAULT_REGS = 5;

    localparam logic [OPCODE_W-1:0] OP_CLASSIFY = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_MATCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WR_MASK  = 2'd2;

    localparam logic [2:0] REG_RULE_COUNT = 3'd0;
    localparam logic [2:0] REG_DEFAULT0   = 3'd1;
    localparam logic [2:0] REG_DEFAULT1   = 3'd2;
    localparam logic [2:0] REG_DEFAULT2   = 3'd3;
    localparam logic [2:0] REG_DEFAULT3   = 3'd4;
    localparam logic [2:0] REG_DEFAULT4   = 3'd5;

    localparam logic [PROTO_W-1:0]  PROTO_UDP     = 8'd17;
    localparam logic [PROTO_W-1:0]  PROTO_TCP     = 8'd6;
    localparam logic [ACTION_W-1:0] ACTION_ACCEPT = 8'd1;

    localparam int FLG_IN    = 0;
    localparam int FLG_OUT   = 1;
    localparam int FLG_SRC   = 2;
    localparam int FLG_DST   = 3;
    localparam int FLG_PROTO = 4;
    localparam int FLG_SPORT = 5;
    localparam int FLG_DPORT = 6;

    typedef struct packed {
        logic [IF_W-1:0]    in_if;
        logic [IF_W-1:0]    out_if;
        logic [ADDR_W-1:0]  src_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  src_port;
        logic [PORT_W-1:0]  dst_port;
    } t_match_word;

    typedef struct packed {
        logic [ADDR_W-1:0]   src_mask;
        logic [ADDR_W-1:0]   dst_mask;
        logic [ACTION_W-1:0] action;
        logic [FLAGS_W-1:0]  flags;
    } t_mask_word;

    typedef struct packed {
        logic start;
        logic wr_match;
        logic wr_mask;
        logic step;
        logic store_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic empty;
        logic all_issued;
        logic hit;
        logic last_cmp;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/first_match_packet_filter.sv
// Top level of the first-match packet filter: register port, controller and datapath.
//
//  channel  direction  handshake                      payload
//  in       input      i_in_valid / o_in_stall        i_opcode .. i_rule_action
//  out      output     o_out_valid / i_out_stall      o_verdict, o_rule_hit, o_hit_index
//  cfg      input      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Rule writes do not hold off the input. A classify walks the rule table one rule per cycle
// through the registered read port of the rule memories and stops at the first hit or after
// the last rule; an empty table goes straight to the result. Reset clears control state and
// the rule count and sets the default actions to accept; rule memories hold garbage until
// written. A stalled output holds its item while the next item is accepted; a finished
// classify waits only if the output register is still full and the output is stalled.
`default_nettype none

module first_match_packet_filter #(
    parameter int MAX_RULES  = 64,
    parameter int HOOK_COUNT = 5
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [fmpf_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [fmpf_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [fmpf_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                      pready,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [fmpf_pkg::OPCODE_W-1:0]        i_opcode,
    input  wire logic [fmpf_pkg::IDX_W-1:0]           i_rule_index,
    input  wire logic [fmpf_pkg::HOOK_W-1:0]          i_hook,
    input  wire logic [fmpf_pkg::IF_W-1:0]            i_in_interface,
    input  wire logic [fmpf_pkg::IF_W-1:0]            i_out_interface,
    input  wire logic [fmpf_pkg::ADDR_W-1:0]          i_src_address,
    input  wire logic [fmpf_pkg::ADDR_W-1:0]          i_dst_address,
    input  wire logic [fmpf_pkg::PROTO_W-1:0]         i_protocol,
    input  wire logic [fmpf_pkg::PORT_W-1:0]          i_src_port,
    input  wire logic [fmpf_pkg::PORT_W-1:0]          i_dst_port,
    input  wire logic [fmpf_pkg::FLAGS_W-1:0]         i_match_flags,
    input  wire logic [fmpf_pkg::ACTION_W-1:0]        i_rule_action,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic      [fmpf_pkg::ACTION_W-1:0]        o_verdict,
    output logic                                      o_rule_hit,
    output logic      [fmpf_pkg::IDX_W-1:0]           o_hit_index
);

    import fmpf_pkg::*;

    logic [COUNT_W-1:0]                     r_rule_count;
    logic [DEFAULT_REGS-1:0][ACTION_W-1:0]  r_default;
    logic                                   w_cfg_wr;
    logic [2:0]                             w_reg_idx;
    logic [2:0]                             w_def_sel;
    t_ctl_cmd                               w_cmd;
    t_dp_status                             w_status;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[4:2];
    assign w_def_sel = w_reg_idx - REG_DEFAULT0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_count <= '0;
            r_default    <= {DEFAULT_REGS{ACTION_ACCEPT}};
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_RULE_COUNT: begin
                    r_rule_count <= pwdata[COUNT_W-1:0];
                end
                REG_DEFAULT0, REG_DEFAULT1, REG_DEFAULT2, REG_DEFAULT3, REG_DEFAULT4: begin
                    r_default[w_def_sel] <= pwdata[ACTION_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_RULE_COUNT: begin
                prdata = CFG_DATA_W'(r_rule_count);
            end
            REG_DEFAULT0, REG_DEFAULT1, REG_DEFAULT2, REG_DEFAULT3, REG_DEFAULT4: begin
                prdata = CFG_DATA_W'(r_default[w_def_sel]);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    fmpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    fmpf_dp #(
        .MAX_RULES  (MAX_RULES),
        .HOOK_COUNT (HOOK_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_rule_index    (i_rule_index),
        .i_hook          (i_hook),
        .i_in_interface  (i_in_interface),
        .i_out_interface (i_out_interface),
        .i_src_address   (i_src_address),
        .i_dst_address   (i_dst_address),
        .i_protocol      (i_protocol),
        .i_src_port      (i_src_port),
        .i_dst_port      (i_dst_port),
        .i_match_flags   (i_match_flags),
        .i_rule_action   (i_rule_action),
        .i_rule_count    (r_rule_count),
        .i_default       (r_default),
        .o_status        (w_status),
        .o_verdict       (o_verdict),
        .o_rule_hit      (o_rule_hit),
        .o_hit_index     (o_hit_index)
    );

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rule_hit |-> o_hit_index == '0)
        else $error("hit index nonzero on a miss");

    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_opcode == OP_CLASSIFY) |=> o_in_stall)
        else $error("classify did not hold off the input");

    a_write_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && ((i_opcode == OP_WR_MATCH) || (i_opcode == OP_WR_MASK))
        |=> !o_in_stall)
        else $error("rule write stalled the input");

    a_no_hit_on_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rule_hit |-> r_rule_count != '0)
        else $error("rule hit with an empty table");

endmodule

`default_nettype wire

// File: rtl/fmpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fmpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                          i_wr_data,
    input  wire logic                                      i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/fmpf_ctrl.sv
// Controller state machine: item acceptance, rule walk sequencing, result handoff.
`default_nettype none

module fmpf_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic [fmpf_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire logic                           i_out_stall,
    input  wire fmpf_pkg::t_dp_status           i_status,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output fmpf_pkg::t_ctl_cmd                  o_cmd
);

    import fmpf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.start     = w_accept && (i_opcode == OP_CLASSIFY);
        o_cmd.wr_match  = w_accept && (i_opcode == OP_WR_MATCH);
        o_cmd.wr_mask   = w_accept && (i_opcode == OP_WR_MASK);
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = i_status.empty ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                if (i_status.hit || i_status.last_cmp) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = !i_status.all_issued;
                end
            end
            S_DONE: begin
                o_cmd.store_out = !r_out_valid || !i_out_stall;
                if (o_cmd.store_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.store_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fmpf_dp.sv
// Datapath: rule tables, packet registers, per-rule compare and result registers.
`default_nettype none

module fmpf_dp #(
    parameter int MAX_RULES  = 64,
    parameter int HOOK_COUNT = 5
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire fmpf_pkg::t_ctl_cmd                          i_cmd,
    input  wire logic [fmpf_pkg::IDX_W-1:0]                  i_rule_index,
    input  wire logic [fmpf_pkg::HOOK_W-1:0]                 i_hook,
    input  wire logic [fmpf_pkg::IF_W-1:0]                   i_in_interface,
    input  wire logic [fmpf_pkg::IF_W-1:0]                   i_out_interface,
    input  wire logic [fmpf_pkg::ADDR_W-1:0]                 i_src_address,
    input  wire logic [fmpf_pkg::ADDR_W-1:0]                 i_dst_address,
    input  wire logic [fmpf_pkg::PROTO_W-1:0]                i_protocol,
    input  wire logic [fmpf_pkg::PORT_W-1:0]                 i_src_port,
    input  wire logic [fmpf_pkg::PORT_W-1:0]                 i_dst_port,
    input  wire logic [fmpf_pkg::FLAGS_W-1:0]                i_match_flags,
    input  wire logic [fmpf_pkg::ACTION_W-1:0]               i_rule_action,
    input  wire logic [fmpf_pkg::COUNT_W-1:0]                i_rule_count,
    input  wire logic [fmpf_pkg::DEFAULT_REGS-1:0][fmpf_pkg::ACTION_W-1:0] i_default,
    output fmpf_pkg::t_dp_status                             o_status,
    output logic [fmpf_pkg::ACTION_W-1:0]                    o_verdict,
    output logic                                             o_rule_hit,
    output logic [fmpf_pkg::IDX_W-1:0]                       o_hit_index
);

    import fmpf_pkg::*;

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int NW = $clog2(MAX_RULES + 1);

    t_match_word         w_match_wr;
    t_mask_word          w_mask_wr;
    t_match_word         w_match_rd;
    t_mask_word          w_mask_rd;
    t_match_word         r_pkt;
    logic [AW+IDX_W-1:0] w_idx_ext;
    logic [AW-1:0]       w_wr_addr;
    logic                w_idx_ok;
    logic [NW-1:0]       w_n;
    logic [NW-1:0]       r_rd_idx;
    logic [NW-1:0]       r_cmp_idx;
    logic                r_cmp_valid;
    logic [NW+IDX_W-1:0] w_cmp_ext;
    logic                w_hook_ok;
    logic [ACTION_W-1:0] w_start_verdict;
    logic                w_match;
    logic                w_l4;
    logic [ACTION_W-1:0] r_res_verdict;
    logic                r_res_hit;
    logic [IDX_W-1:0]    r_res_index;

    assign w_idx_ext = (AW + IDX_W)'(i_rule_index);
    assign w_wr_addr = w_idx_ext[AW-1:0];
    assign w_idx_ok  = (32'(i_rule_index) < MAX_RULES);

    assign w_match_wr = '{in_if:    i_in_interface,
                          out_if:   i_out_interface,
                          src_addr: i_src_address,
                          dst_addr: i_dst_address,
                          proto:    i_protocol,
                          src_port: i_src_port,
                          dst_port: i_dst_port};

    assign w_mask_wr = '{src_mask: i_src_address,
                         dst_mask: i_dst_address,
                         action:   i_rule_action,
                         flags:    i_match_flags};

    fmpf_ram #(
        .WIDTH ($bits(t_match_word)),
        .DEPTH (MAX_RULES)
    ) u_match_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_match && w_idx_ok),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_match_wr),
        .i_rd_en   (i_cmd.step),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (w_match_rd)
    );

    fmpf_ram #(
        .WIDTH ($bits(t_mask_word)),
        .DEPTH (MAX_RULES)
    ) u_mask_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_mask && w_idx_ok),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_mask_wr),
        .i_rd_en   (i_cmd.step),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (w_mask_rd)
    );

    always_comb begin
        if (32'(i_rule_count) > MAX_RULES) begin
            w_n = NW'(MAX_RULES);
        end else begin
            w_n = NW'(i_rule_count);
        end
    end

    assign w_hook_ok = (32'(i_hook) < HOOK_COUNT) && (32'(i_hook) < DEFAULT_REGS);

    always_comb begin
        w_start_verdict = ACTION_ACCEPT;
        if ((w_n != '0) && w_hook_ok) begin
            w_start_verdict = i_default[i_hook];
        end
    end

    always_comb begin
        w_l4    = w_match_rd.proto inside {PROTO_UDP, PROTO_TCP};
        w_match = 1'b1;
        if (w_mask_rd.flags[FLG_IN] && (w_match_rd.in_if != r_pkt.in_if)) begin
            w_match = 1'b0;
        end
        if (w_mask_rd.flags[FLG_OUT] && (w_match_rd.out_if != r_pkt.out_if)) begin
            w_match = 1'b0;
        end
        if (w_mask_rd.flags[FLG_SRC] && ((w_match_rd.src_addr & w_mask_rd.src_mask)
                != (r_pkt.src_addr & w_mask_rd.src_mask))) begin
            w_match = 1'b0;
        end
        if (w_mask_rd.flags[FLG_DST] && ((w_match_rd.dst_addr & w_mask_rd.dst_mask)
                != (r_pkt.dst_addr & w_mask_rd.dst_mask))) begin
            w_match = 1'b0;
        end
        if (w_mask_rd.flags[FLG_PROTO] && (w_match_rd.proto != r_pkt.proto)) begin
            w_match = 1'b0;
        end
        if (w_l4 && w_mask_rd.flags[FLG_SPORT] && (w_match_rd.src_port != r_pkt.src_port)) begin
            w_match = 1'b0;
        end
        if (w_l4 && w_mask_rd.flags[FLG_DPORT] && (w_match_rd.dst_port != r_pkt.dst_port)) begin
            w_match = 1'b0;
        end
    end

    assign w_cmp_ext = (NW + IDX_W)'(r_cmp_idx);

    assign o_status.empty      = (w_n == '0);
    assign o_status.all_issued = (r_rd_idx == w_n);
    assign o_status.hit        = r_cmp_valid && w_match;
    assign o_status.last_cmp   = r_cmp_valid && (NW'(r_cmp_idx + NW'(1)) == w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pkt         <= w_match_wr;
            r_rd_idx      <= '0;
            r_res_verdict <= w_start_verdict;
            r_res_hit     <= 1'b0;
            r_res_index   <= '0;
        end else begin
            if (i_cmd.step) begin
                r_rd_idx  <= r_rd_idx + NW'(1);
                r_cmp_idx <= r_rd_idx;
            end
            if (o_status.hit) begin
                r_res_verdict <= w_mask_rd.action;
                r_res_hit     <= 1'b1;
                r_res_index   <= w_cmp_ext[IDX_W-1:0];
            end
        end
        if (i_cmd.store_out) begin
            o_verdict   <= r_res_verdict;
            o_rule_hit  <= r_res_hit;
            o_hit_index <= r_res_index;
        end
    end

endmodule

`default_nettype wire
